// ===== src/weam_pkg.sv =====
// Package with the shared constants, types and the helper function of the activity monitor.
`default_nettype none

package weam_pkg;

  // Ring geometry and field widths.
  localparam int RING_DEPTH    = 2048;
  localparam int CHANNEL_SLOTS = 16;
  localparam int IDX_W         = $clog2(RING_DEPTH);
  localparam int TIME_W        = 64;
  localparam int CHAN_W        = 8;
  localparam int CNT_W         = 12;
  localparam int CHCNT_W       = 5;
  localparam int POP_W         = $clog2(CHANNEL_SLOTS + 1);

  // Window length after reset: one tenth of a second in nanoseconds.
  localparam logic [TIME_W-1:0] WINDOW_RESET = TIME_W'(100000000);

  // Saturation limits of the reported counts.
  localparam logic [CNT_W-1:0]   COUNT_MAX   = {CNT_W{1'b1}};
  localparam logic [CHCNT_W-1:0] CHCOUNT_MAX = {CHCNT_W{1'b1}};

  typedef enum logic [1:0] {
    OP_REC_RAW = 2'd0,
    OP_REC_DEC = 2'd1,
    OP_QUERY   = 2'd2,
    OP_CLEAR   = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  // Number of channels seen, saturated to the width of the reported field.
  function automatic logic [CHCNT_W-1:0] chan_popcount(input logic [CHANNEL_SLOTS-1:0] set);
    logic [POP_W-1:0] n;
    n = '0;
    for (int i = 0; i < CHANNEL_SLOTS; i++) begin
      n = n + POP_W'(set[i]);
    end
    if (32'(n) > 32'(CHCOUNT_MAX)) begin
      return CHCOUNT_MAX;
    end
    return CHCNT_W'(n);
  endfunction

endpackage

`default_nettype wire

// ===== src/weam_in_if.sv =====
// Interface of the input channel: valid, ready and one command transaction.
`default_nettype none

interface weam_in_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     opcode;
  logic [weam_pkg::TIME_W-1:0]    current_time;
  logic [weam_pkg::CHAN_W-1:0]    event_channel;

  modport source (output valid, output opcode, output current_time, output event_channel,
                  input ready);
  modport sink (input valid, input opcode, input current_time, input event_channel,
                output ready);
endinterface

`default_nettype wire

// ===== src/weam_out_if.sv =====
// Interface of the result channel: valid, ready and one query result transaction.
`default_nettype none

interface weam_out_if;
  logic                            valid;
  logic                            ready;
  logic [weam_pkg::TIME_W-1:0]     raw_latest_time;
  logic [weam_pkg::CNT_W-1:0]      raw_window_count;
  logic [weam_pkg::TIME_W-1:0]     raw_sequence_total;
  logic [weam_pkg::TIME_W-1:0]     decoded_latest_time;
  logic [weam_pkg::CNT_W-1:0]      decoded_window_count;
  logic [weam_pkg::CHCNT_W-1:0]    decoded_channel_count;
  logic [weam_pkg::TIME_W-1:0]     decoded_sequence_total;

  modport source (output valid, output raw_latest_time, output raw_window_count,
                  output raw_sequence_total, output decoded_latest_time,
                  output decoded_window_count, output decoded_channel_count,
                  output decoded_sequence_total, input ready);
  modport sink (input valid, input raw_latest_time, input raw_window_count,
                input raw_sequence_total, input decoded_latest_time,
                input decoded_window_count, input decoded_channel_count,
                input decoded_sequence_total, output ready);
endinterface

`default_nettype wire

// ===== src/windowed_event_activity_monitor_core.sv =====
// Top level of the windowed event activity monitor: two event rings and a query scanner.
//
// Usage:
//   in_if carries command transactions (record raw, record decoded, query, clear).
//   out_if carries one result transaction for each query; records and clears give none.
//   cfg_we / cfg_wdata write the window length in nanoseconds; the user must
//   write it only while idle, and the block itself does not enforce this.
// Sequencing:
//   A record is written into its ring memory at the edge where it is accepted, and a
//   clear resets the sequences there; the next transaction can follow right away.
//   A query reads both ring memories in parallel, one entry per cycle over all
//   RING_DEPTH entries, then drains a three-stage read and compare pipeline. Input
//   is not taken during that scan; each ring memory's single read port sets its length.
// Reset:
//   Sequences, fill state and the window length are reset at once. Ring entries
//   beyond the fill point of a ring read as empty, so no clearing pass is needed.
//   A clear transaction works the same way, but keeps the window length.
// Stalls:
//   A result waits in the output register until taken. Records and clears are still
//   accepted meanwhile; a new query scans but holds its result until the old one leaves.
`default_nettype none

module windowed_event_activity_monitor_core (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  weam_in_if.sink                           in_if,
  weam_out_if.source                        out_if,
  input  wire logic                         cfg_we,
  input  wire logic [weam_pkg::TIME_W-1:0]  cfg_wdata
);
  import weam_pkg::*;

  // Ring memories: raw entries keep only the time, decoded ones time and channel.
  logic [TIME_W-1:0]        raw_mem [RING_DEPTH];
  logic [CHAN_W+TIME_W-1:0] dec_mem [RING_DEPTH];

  // Control state.
  state_t               state_r, state_nxt;
  logic [TIME_W-1:0]    window_r;
  logic [TIME_W-1:0]    raw_seq_r;
  logic [TIME_W-1:0]    dec_seq_r;
  logic                 raw_wrap_r;
  logic                 dec_wrap_r;
  logic [IDX_W-1:0]     scan_idx_r;
  logic                 s1_vld_r;
  logic                 s2_vld_r;
  logic                 out_valid_r;

  // Datapath registers.
  logic [TIME_W-1:0]        now_r;
  logic [IDX_W-1:0]         s1_idx_r;
  logic [TIME_W-1:0]        raw_rd_r;
  logic [CHAN_W+TIME_W-1:0] dec_rd_r;
  logic                     raw_hit_r, dec_hit_r;
  logic [TIME_W-1:0]        raw_t_r, dec_t_r;
  logic [TIME_W-1:0]        raw_age_r, dec_age_r;
  logic [CHAN_W-1:0]        dec_ch_r;
  logic [TIME_W-1:0]        raw_lt_r, dec_lt_r;
  logic [CNT_W-1:0]         raw_cnt_r, dec_cnt_r;
  logic [CHANNEL_SLOTS-1:0] chanset_r;
  logic [TIME_W-1:0]        o_raw_lt_r, o_raw_seq_r, o_dec_lt_r, o_dec_seq_r;
  logic [CNT_W-1:0]         o_raw_cnt_r, o_dec_cnt_r;
  logic [CHCNT_W-1:0]       o_chcnt_r;

  // Handshake and sequencing controls.
  logic       accept;
  logic       start_scan;
  logic       scan_issue;
  logic       load_out;
  logic       in_ready;
  opcode_t    op;

  assign op        = opcode_t'(in_if.opcode);
  assign accept    = in_if.valid && in_ready;
  assign in_if.ready = in_ready;

  // State machine: idle takes transactions, scan issues reads, drain empties the
  // pipeline, done waits for the output register to be free.
  always_comb begin
    state_nxt  = state_r;
    in_ready   = 1'b0;
    start_scan = 1'b0;
    scan_issue = 1'b0;
    load_out   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_if.valid && op == OP_QUERY) begin
          start_scan = 1'b1;
          state_nxt  = ST_SCAN;
        end
      end
      ST_SCAN: begin
        scan_issue = 1'b1;
        if (scan_idx_r == IDX_W'(RING_DEPTH - 1)) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!s1_vld_r && !s2_vld_r) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_if.ready) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Window length register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= WINDOW_RESET;
    end else if (cfg_we) begin
      window_r <= cfg_wdata;
    end
  end

  // Sequences and fill state; a ring has wrapped once its slot index rolled over.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_seq_r  <= '0;
      dec_seq_r  <= '0;
      raw_wrap_r <= 1'b0;
      dec_wrap_r <= 1'b0;
    end else if (accept) begin
      case (op)
        OP_REC_RAW: begin
          raw_seq_r <= raw_seq_r + TIME_W'(1);
          if (raw_seq_r[IDX_W-1:0] == IDX_W'(RING_DEPTH - 1)) begin
            raw_wrap_r <= 1'b1;
          end
        end
        OP_REC_DEC: begin
          dec_seq_r <= dec_seq_r + TIME_W'(1);
          if (dec_seq_r[IDX_W-1:0] == IDX_W'(RING_DEPTH - 1)) begin
            dec_wrap_r <= 1'b1;
          end
        end
        OP_CLEAR: begin
          raw_seq_r  <= '0;
          dec_seq_r  <= '0;
          raw_wrap_r <= 1'b0;
          dec_wrap_r <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  // Ring memory writes on records.
  always_ff @(posedge clk) begin
    if (accept && op == OP_REC_RAW) begin
      raw_mem[raw_seq_r[IDX_W-1:0]] <= in_if.current_time;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && op == OP_REC_DEC) begin
      dec_mem[dec_seq_r[IDX_W-1:0]] <= {in_if.event_channel, in_if.current_time};
    end
  end

  // Ring memory reads during a scan, registered.
  always_ff @(posedge clk) begin
    raw_rd_r <= raw_mem[scan_idx_r];
  end

  always_ff @(posedge clk) begin
    dec_rd_r <= dec_mem[scan_idx_r];
  end

  // Scan address counter and stage valid flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_idx_r <= '0;
      s1_vld_r   <= 1'b0;
      s2_vld_r   <= 1'b0;
    end else begin
      if (start_scan) begin
        scan_idx_r <= '0;
      end else if (scan_issue) begin
        scan_idx_r <= scan_idx_r + IDX_W'(1);
      end
      s1_vld_r <= scan_issue;
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_idx_r <= scan_idx_r;
    if (start_scan) begin
      now_r <= in_if.current_time;
    end
  end

  // Stage two: mask unwritten entries, test for a usable time and form the age.
  logic              raw_fill_ok, dec_fill_ok;
  logic [TIME_W-1:0] raw_t, dec_t;

  always_comb begin
    raw_fill_ok = raw_wrap_r || (s1_idx_r < raw_seq_r[IDX_W-1:0]);
    dec_fill_ok = dec_wrap_r || (s1_idx_r < dec_seq_r[IDX_W-1:0]);
    raw_t       = raw_fill_ok ? raw_rd_r : '0;
    dec_t       = dec_fill_ok ? dec_rd_r[TIME_W-1:0] : '0;
  end

  always_ff @(posedge clk) begin
    raw_hit_r <= (raw_t != '0) && (raw_t <= now_r);
    dec_hit_r <= (dec_t != '0) && (dec_t <= now_r);
    raw_t_r   <= raw_t;
    dec_t_r   <= dec_t;
    raw_age_r <= now_r - raw_t;
    dec_age_r <= now_r - dec_t;
    dec_ch_r  <= dec_rd_r[CHAN_W+TIME_W-1:TIME_W];
  end

  // Stage three: accumulate newest time, window counts and the channel set.
  logic raw_in_win, dec_in_win, dec_ch_ok;

  always_comb begin
    raw_in_win = raw_hit_r && (raw_age_r <= window_r);
    dec_in_win = dec_hit_r && (dec_age_r <= window_r);
    dec_ch_ok  = 32'(dec_ch_r) < CHANNEL_SLOTS;
  end

  always_ff @(posedge clk) begin
    if (start_scan) begin
      raw_lt_r  <= '0;
      dec_lt_r  <= '0;
      raw_cnt_r <= '0;
      dec_cnt_r <= '0;
      chanset_r <= '0;
    end else if (s2_vld_r) begin
      if (raw_hit_r && raw_t_r > raw_lt_r) begin
        raw_lt_r <= raw_t_r;
      end
      if (dec_hit_r && dec_t_r > dec_lt_r) begin
        dec_lt_r <= dec_t_r;
      end
      if (raw_in_win && raw_cnt_r != COUNT_MAX) begin
        raw_cnt_r <= raw_cnt_r + CNT_W'(1);
      end
      if (dec_in_win && dec_cnt_r != COUNT_MAX) begin
        dec_cnt_r <= dec_cnt_r + CNT_W'(1);
      end
      if (dec_in_win && dec_ch_ok) begin
        chanset_r <= chanset_r | (CHANNEL_SLOTS'(1) << dec_ch_r);
      end
    end
  end

  // Output register and its valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      o_raw_lt_r  <= raw_lt_r;
      o_raw_cnt_r <= raw_cnt_r;
      o_raw_seq_r <= raw_seq_r;
      o_dec_lt_r  <= dec_lt_r;
      o_dec_cnt_r <= dec_cnt_r;
      o_chcnt_r   <= chan_popcount(chanset_r);
      o_dec_seq_r <= dec_seq_r;
    end
  end

  assign out_if.valid                  = out_valid_r;
  assign out_if.raw_latest_time        = o_raw_lt_r;
  assign out_if.raw_window_count       = o_raw_cnt_r;
  assign out_if.raw_sequence_total     = o_raw_seq_r;
  assign out_if.decoded_latest_time    = o_dec_lt_r;
  assign out_if.decoded_window_count   = o_dec_cnt_r;
  assign out_if.decoded_channel_count  = o_chcnt_r;
  assign out_if.decoded_sequence_total = o_dec_seq_r;

endmodule

`default_nettype wire
